>>> rtl/rmts_pkg.sv
`default_nettype none

package rmts_pkg;

	localparam int TASK_SLOTS  = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int WORK_W      = 16;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 32;
	localparam int RUN_W       = 4;
	localparam int TICK_W      = 16;

	// Operation of the shared entry unit.
	localparam logic MODE_SCAN   = 1'b0;
	localparam logic MODE_UPDATE = 1'b1;

	typedef logic [WORK_W-1:0] work_t;

	typedef struct packed {
		logic  mode;
		logic  restart;
		logic  found;
		logic  is_pick;
		work_t best;
		work_t period;
		work_t budget;
		work_t remaining;
		work_t phase;
	} step_in_t;

	typedef struct packed {
		work_t remaining;
		work_t phase;
		logic  better;
		logic  pending;
	} step_out_t;

endpackage

`default_nettype wire

>>> rtl/rmts_step_unit.sv
`default_nettype none

// Works on one task entry per cycle: a priority compare and restart reload during
// the scan pass, or the phase advance and budget reload during the update pass.
module rmts_step_unit (
	input  rmts_pkg::step_in_t  step_in,
	output rmts_pkg::step_out_t step_out
);

	always_comb begin
		logic                  enabled;
		rmts_pkg::work_t       rem_eff;
		rmts_pkg::work_t       rem_dec;
		logic [rmts_pkg::WORK_W:0] phase_inc;

		enabled   = (step_in.period != '0);
		rem_eff   = (step_in.restart && enabled) ? step_in.budget : step_in.remaining;
		rem_dec   = step_in.is_pick ? (step_in.remaining - rmts_pkg::WORK_W'(1))
		                            : step_in.remaining;
		phase_inc = {1'b0, step_in.phase} + (rmts_pkg::WORK_W + 1)'(1);
		step_out  = '0;

		if (step_in.mode == rmts_pkg::MODE_SCAN) begin
			step_out.remaining = rem_eff;
			step_out.phase     = step_in.restart ? '0 : step_in.phase;
			step_out.better    = enabled && (rem_eff != '0) &&
			                     (!step_in.found || (step_in.period < step_in.best));
		end else begin
			if (!enabled) begin
				step_out.remaining = rem_dec;
				step_out.phase     = '0;
				step_out.pending   = 1'b0;
			end else if (phase_inc >= {1'b0, step_in.period}) begin
				step_out.remaining = step_in.budget;
				step_out.phase     = '0;
				step_out.pending   = (step_in.budget != '0);
			end else begin
				step_out.remaining = rem_dec;
				step_out.phase     = phase_inc[rmts_pkg::WORK_W-1:0];
				step_out.pending   = (rem_dec != '0);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/rate_monotonic_tick_scheduler_core.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tdata[0] restart, bits 7..1 zero
// m_*       out        m_tvalid / m_tready  running_task, tick_count, pending_mask
// cfg_*     in         cfg_valid / cfg_ready cfg_index (task slot), cfg_data (timing)
//
// For each tick item, a scan pass and an update pass each walk the task table one
// entry a cycle through the single shared entry unit, then the done state loads the
// output register.
// The output register lets a new tick item be taken while the last result waits;
// the block stalls only in its final cycle if that register is still full.
// Reset clears all timing registers, work and phase counters, and the tick time.
// The configuration port is ready only while the sequencer is idle.
module rate_monotonic_tick_scheduler_core #(
	parameter int MAX_TASKS = 8,
	parameter int TIME_BITS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output      logic                             s_tready,
	input  wire logic [rmts_pkg::IN_TDATA_W-1:0]  s_tdata,  // [0] restart, [7:1] zero
	output      logic                             m_tvalid,
	input  wire logic                             m_tready,
	// [3:0] running_task, [19:4] tick_count, [27:20] pending_mask, [31:28] zero
	output      logic [rmts_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  wire logic                             cfg_valid,
	output      logic                             cfg_ready,
	input  wire logic [rmts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rmts_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_UPDATE = 2'd2;
	localparam logic [1:0] S_DONE   = 2'd3;

	// Task table: timing word, remaining work and phase for each slot.
	logic [rmts_pkg::CFG_DATA_W-1:0] timing_q [MAX_TASKS];
	rmts_pkg::work_t                 rem_q    [MAX_TASKS];
	rmts_pkg::work_t                 phase_q  [MAX_TASKS];
	logic [TIME_BITS-1:0]            time_q;

	// Sequencer state and the running result of the scan.
	logic [1:0]              state_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    restart_q;
	logic                    found_q;
	logic [IDX_W-1:0]        pick_q;
	rmts_pkg::work_t         best_q;
	logic [MAX_TASKS-1:0]    mask_q;

	// Output register.
	logic                            out_valid_q;
	logic [rmts_pkg::RUN_W-1:0]      out_run_q;
	logic [rmts_pkg::TICK_W-1:0]     out_tick_q;
	logic [rmts_pkg::TASK_SLOTS-1:0] out_mask_q;

	rmts_pkg::step_in_t  step_in;
	rmts_pkg::step_out_t step_out;
	logic                last_entry;
	logic                cfg_hit;

	assign last_entry = (idx_q == IDX_W'(MAX_TASKS - 1));
	assign cfg_hit    = cfg_valid && cfg_ready &&
	                    ({1'b0, cfg_index} < (rmts_pkg::CFG_IDX_W + 1)'(MAX_TASKS));

	// The shared unit always looks at the entry under the walk index.
	always_comb begin
		step_in           = '0;
		step_in.mode      = (state_q == S_UPDATE) ? rmts_pkg::MODE_UPDATE : rmts_pkg::MODE_SCAN;
		step_in.restart   = restart_q;
		step_in.found     = found_q;
		step_in.is_pick   = found_q && (pick_q == idx_q);
		step_in.best      = best_q;
		step_in.period    = timing_q[idx_q][31:16];
		step_in.budget    = timing_q[idx_q][15:0];
		step_in.remaining = rem_q[idx_q];
		step_in.phase     = phase_q[idx_q];
	end

	rmts_step_unit u_step (
		.step_in  (step_in),
		.step_out (step_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_TASKS; k++) begin
				timing_q[k] <= '0;
				rem_q[k]    <= '0;
				phase_q[k]  <= '0;
			end
			time_q      <= '0;
			state_q     <= S_IDLE;
			idx_q       <= '0;
			restart_q   <= 1'b0;
			found_q     <= 1'b0;
			pick_q      <= '0;
			best_q      <= '0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
			out_run_q   <= '0;
			out_tick_q  <= '0;
			out_mask_q  <= '0;
		end else begin
			// In the final cycle the sequencer itself decides the output valid.
			if (out_valid_q && m_tready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end

			// A write loads the new budget as remaining work and restarts the phase.
			// Writes arrive only while the sequencer is idle.
			if (cfg_hit) begin
				timing_q[cfg_index[IDX_W-1:0]] <= cfg_data;
				rem_q[cfg_index[IDX_W-1:0]]    <= cfg_data[15:0];
				phase_q[cfg_index[IDX_W-1:0]]  <= '0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						restart_q <= s_tdata[0];
						idx_q     <= '0;
						found_q   <= 1'b0;
						mask_q    <= '0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					// A restart reloads each entry as the scan passes it.
					rem_q[idx_q]   <= step_out.remaining;
					phase_q[idx_q] <= step_out.phase;
					if (step_out.better) begin
						found_q <= 1'b1;
						best_q  <= step_in.period;
						pick_q  <= idx_q;
					end
					if (last_entry) begin
						if (restart_q) begin
							time_q <= '0;
						end
						idx_q   <= '0;
						state_q <= S_UPDATE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_UPDATE: begin
					rem_q[idx_q]   <= step_out.remaining;
					phase_q[idx_q] <= step_out.phase;
					mask_q[idx_q]  <= step_out.pending;
					if (last_entry) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_run_q   <= found_q ? (rmts_pkg::RUN_W'(pick_q) + rmts_pkg::RUN_W'(1))
						                       : '0;
						out_tick_q  <= rmts_pkg::TICK_W'(time_q);
						out_mask_q  <= rmts_pkg::TASK_SLOTS'(mask_q);
						time_q      <= time_q + TIME_BITS'(1);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {4'd0, out_mask_q, out_tick_q, out_run_q};

endmodule

`default_nettype wire

>>> tb/rate_monotonic_tick_scheduler_core_test.sv
module rate_monotonic_tick_scheduler_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_TASKS    = 8;
	// Random ticks to send after the directed part.
	localparam int RAND_TICKS   = 1630;
	// Cycles with no item moving on any channel before the run is called hung.
	localparam int STALL_LIMIT  = 3000;
	// Length of the one long receiver hold-off.
	localparam int LONG_HOLD    = 400;
	// The end pause allows for one full tick and some margin.
	localparam int DRAIN_CYCLES = 2 * NUM_TASKS + 2 + 8;

	// One scheduler result as it appears on the output stream.
	typedef struct packed {
		logic [rmts_pkg::RUN_W-1:0]  running;
		logic [rmts_pkg::TICK_W-1:0] tick;
		logic [NUM_TASKS-1:0]        pending;
	} tick_result_t;

	typedef struct packed {
		logic [rmts_pkg::CFG_IDX_W-1:0]  index;
		logic [rmts_pkg::CFG_DATA_W-1:0] data;
	} timing_write_t;

	// Ready patterns the receiver switches between.
	typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             s_tvalid  = 1'b0;
	logic                             s_tready;
	logic [rmts_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;  // [0] restart, [7:1] zero
	logic                             m_tvalid;
	logic                             m_tready  = 1'b0;
	// [3:0] running_task, [19:4] tick_count, [27:20] pending_mask, [31:28] zero
	logic [rmts_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [rmts_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [rmts_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

	// Scheduler state as the testbench predicts it.
	logic [31:0] timing_regs [NUM_TASKS];
	logic [15:0] work_left   [NUM_TASKS];
	logic [15:0] phase_ctr   [NUM_TASKS];
	logic [15:0] now_ticks;

	// Restart bits waiting to be sent, timing writes waiting to be sent, and the
	// results the scheduler owes us, oldest first.
	logic          tick_req_q  [$];
	timing_write_t timing_wr_q [$];
	tick_result_t  due_q       [$];

	int       mismatches    = 0;
	int       ticks_sent    = 0;
	int       restarts_sent = 0;
	int       timing_writes = 0;
	int       results_seen  = 0;
	int       idle_seen     = 0;
	int       gap_left      = 0;
	int       burst_left    = 0;
	int       hold_left     = 0;
	int       rx_cycle      = 0;
	int       quiet_cycles  = 0;
	logic     hold_req      = 1'b0;
	logic     hold_taken    = 1'b0;
	rx_mode_t rx_mode       = RX_ALWAYS;
	tick_result_t  seen_result;
	tick_result_t  want_result;
	timing_write_t next_write;

	rate_monotonic_tick_scheduler_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Works out the result of one tick and advances the predicted state. A restart
	// reloads enabled budgets and clears phases and time before the selection. The
	// selection takes the enabled task with work left and the shortest period, the
	// lowest index on a tie. Afterwards each enabled task steps its phase and reloads
	// its budget when the phase reaches or passes its period.
	function automatic tick_result_t schedule_tick(input logic restart);
		tick_result_t res;
		logic         found;
		int           pick;
		int           k;
		logic [15:0]  best;
		logic [15:0]  per;
		logic [16:0]  next_phase;
		res   = '0;
		found = 1'b0;
		pick  = 0;
		best  = '0;
		if (restart) begin
			for (k = 0; k < NUM_TASKS; k++) begin
				if (timing_regs[k][31:16] != 0)
					work_left[k] = timing_regs[k][15:0];
				phase_ctr[k] = '0;
			end
			now_ticks = '0;
		end
		for (k = 0; k < NUM_TASKS; k++) begin
			per = timing_regs[k][31:16];
			if (per != 0 && work_left[k] != 0 && (!found || per < best)) begin
				found = 1'b1;
				best  = per;
				pick  = k;
			end
		end
		if (found) begin
			work_left[pick] = work_left[pick] - 16'd1;
			res.running     = rmts_pkg::RUN_W'(pick + 1);
		end
		res.tick = now_ticks;
		for (k = 0; k < NUM_TASKS; k++) begin
			per = timing_regs[k][31:16];
			if (per == 0) begin
				// A disabled task never reloads and never shows as pending.
				phase_ctr[k] = '0;
			end else begin
				next_phase = {1'b0, phase_ctr[k]} + 17'd1;
				if (next_phase >= {1'b0, per}) begin
					phase_ctr[k] = '0;
					work_left[k] = timing_regs[k][15:0];
				end else begin
					phase_ctr[k] = next_phase[15:0];
				end
				res.pending[k] = (work_left[k] != 0);
			end
		end
		now_ticks = now_ticks + 16'd1;
		return res;
	endfunction

	// A random timing word. Most tasks get short periods and small budgets so that
	// they compete; some are disabled, some take the extreme values.
	function automatic logic [31:0] random_timing();
		logic [15:0] per;
		logic [15:0] bud;
		case ($urandom_range(0, 11))
			0:       per = '0;
			1:       per = 16'hFFFF;
			2:       per = 16'($urandom_range(21, 65535));
			default: per = 16'($urandom_range(1, 20));
		endcase
		case ($urandom_range(0, 11))
			0:       bud = '0;
			1:       bud = 16'hFFFF;
			2:       bud = 16'($urandom_range(5, 65535));
			default: bud = 16'($urandom_range(1, 4));
		endcase
		return {per, bud};
	endfunction

	task automatic write_timing(input int idx, input logic [31:0] value);
		timing_wr_q.push_back('{index: rmts_pkg::CFG_IDX_W'(idx), data: value});
	endtask

	task automatic send_ticks(input int count, input logic restart_first);
		for (int i = 0; i < count; i++)
			tick_req_q.push_back(i == 0 ? restart_first : ($urandom_range(0, 15) == 0));
	endtask

	// Blocks until every queued write and tick has been taken and every result has
	// come back; with one result per tick the block is then idle.
	task automatic drain();
		do @(negedge clk);
		while (tick_req_q.size() != 0 || s_tvalid || timing_wr_q.size() != 0 || cfg_valid
			|| due_q.size() != 0);
	endtask

	// Timing write driver. The predicted registers change at the edge where a write
	// is taken, the same edge at which the block takes it.
	always @(posedge clk) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_index <= '0;
			cfg_data  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				timing_regs[cfg_index] = cfg_data;
				work_left[cfg_index]   = cfg_data[15:0];
				phase_ctr[cfg_index]   = '0;
				timing_writes++;
			end
			if (!cfg_valid || cfg_ready) begin
				if (timing_wr_q.size() != 0) begin
					next_write = timing_wr_q.pop_front();
					cfg_index <= next_write.index;
					cfg_data  <= next_write.data;
					cfg_valid <= 1'b1;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// Tick driver. It sends bursts of random length with random gaps between them,
	// holds an item steady while the block stalls, and predicts each tick at the
	// edge where the block takes it.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				due_q.push_back(schedule_tick(s_tdata[0]));
				ticks_sent++;
				if (s_tdata[0])
					restarts_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (tick_req_q.size() != 0) begin
					s_tdata  <= {{(rmts_pkg::IN_TDATA_W - 1){1'b0}}, tick_req_q.pop_front()};
					s_tvalid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						// A third of the bursts run straight into the next one.
						burst_left = $urandom_range(0, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result receiver. It switches between random ready patterns. The one long
	// hold-off is counted here, so the sender keeps offering ticks until the block
	// has filled its output register and stops taking input.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			rx_cycle++;
			if (rx_cycle % 97 == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS: m_tready <= 1'b1;
					RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
					default:   m_tready <= ((rx_cycle % 7) < 4);
				endcase
			end
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Result monitor: each result taken is held against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_result.running = m_tdata[3:0];
			seen_result.tick    = m_tdata[19:4];
			seen_result.pending = m_tdata[27:20];
			results_seen++;
			if (seen_result.running == 0)
				idle_seen++;
			if (due_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got running %0d tick %0d pending %02h",
					$time, seen_result.running, seen_result.tick, seen_result.pending);
				mismatches++;
			end else begin
				want_result = due_q.pop_front();
				check_field("running_task", want_result.running, seen_result.running);
				check_field("tick_count", want_result.tick, seen_result.tick);
				check_field("pending_mask", want_result.pending, seen_result.pending);
			end
		end
	end

	// Hang detector: counts cycles in which no item moves on any channel.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
			|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no item moved for %0d cycles, %0d results still owed",
					$time, STALL_LIMIT, due_q.size());
				$display("rate_monotonic_tick_scheduler_core verification failed");
				$finish;
			end
		end
	end

	initial begin
		int random_ticks;
		int phase_no;
		int n_writes;
		int n_ticks;
		random_ticks = 0;
		phase_no     = 0;
		for (int k = 0; k < NUM_TASKS; k++) begin
			timing_regs[k] = '0;
			work_left[k]   = '0;
			phase_ctr[k]   = '0;
		end
		now_ticks = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Out of reset every task is disabled, so the block idles; the restart
		// tick sends the time back to zero.
		tick_req_q.push_back(1'b0);
		tick_req_q.push_back(1'b1);
		drain();

		// A mixed table: extreme period and budget on task 0, a tie between tasks
		// 1 and 2, a disabled task with a budget, an enabled task with no budget,
		// and a longest-period task with no budget.
		write_timing(0, 32'hFFFF_FFFF);
		write_timing(1, {16'd4, 16'd1});
		write_timing(2, {16'd4, 16'd1});
		write_timing(3, {16'd0, 16'd5});
		write_timing(4, {16'd1, 16'd0});
		write_timing(5, {16'd6, 16'd2});
		write_timing(6, {16'd8, 16'd1});
		write_timing(7, {16'hFFFF, 16'd0});
		drain();
		send_ticks(10, 1'b0);
		tick_req_q.push_back(1'b1);
		send_ticks(3, 1'b0);
		drain();

		// Rewriting a task in mid-period reloads its work and clears its phase.
		write_timing(1, {16'd4, 16'd3});
		drain();
		send_ticks(4, 1'b0);
		drain();

		// Clearing every register leaves nothing to run.
		for (int k = 0; k < NUM_TASKS; k++)
			write_timing(k, 32'h0000_0000);
		drain();
		tick_req_q.push_back(1'b0);
		tick_req_q.push_back(1'b1);
		drain();

		// Random phases: new timing words while idle, then a run of ticks with an
		// occasional restart. One phase carries the long receiver hold-off.
		while (random_ticks < RAND_TICKS) begin
			n_writes = ($urandom_range(0, 3) == 0) ? NUM_TASKS : $urandom_range(1, 4);
			for (int i = 0; i < n_writes; i++)
				write_timing((n_writes == NUM_TASKS) ? i : $urandom_range(0, NUM_TASKS - 1),
					random_timing());
			drain();
			n_ticks = $urandom_range(20, 110);
			if (phase_no == 3) begin
				n_ticks  = 140;
				hold_req = 1'b1;
			end
			send_ticks(n_ticks, 1'($urandom_range(0, 1)));
			random_ticks += n_ticks;
			drain();
			phase_no++;
		end

		// Give the block time to show any result it should not produce.
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (due_q.size() != 0) begin
			$display("%0t: %0d results expected but never seen", $time, due_q.size());
			mismatches += due_q.size();
		end
		$display("Sent %0d ticks (%0d restarts) across %0d timing writes and %0d phases.",
			ticks_sent, restarts_sent, timing_writes, phase_no);
		$display("Checked %0d results, %0d of them idle, with one %0d-cycle receiver hold-off.",
			results_seen, idle_seen, LONG_HOLD);
		if (mismatches == 0) begin
			$display("rate_monotonic_tick_scheduler_core verification clean");
		end else begin
			$display("rate_monotonic_tick_scheduler_core verification failed");
		end
		$finish;
	end

endmodule
